### src/ilb_pkg.sv
// ---------------------------------------------------------------------------
// ilb_pkg: shared definitions for the indexed list buffer
// Command and status codes, request and response layout, cell control type.
// ---------------------------------------------------------------------------
`default_nettype none

package ilb_pkg;

   localparam int DEF_DEPTH         = 64;
   localparam int DEF_ELEMENT_WIDTH = 32;

   // request and response field widths
   localparam int CMD_W   = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int READ_W  = 32;
   localparam int COUNT_W = 7;

   // request layout
   localparam int REQ_CMD_LO  = 0;
   localparam int REQ_POS_LO  = REQ_CMD_LO + CMD_W;
   localparam int REQ_VAL_LO  = REQ_POS_LO + POS_W;
   localparam int REQ_BITS    = REQ_VAL_LO + VALUE_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response layout
   localparam int RSP_STAT_LO  = 0;
   localparam int RSP_READ_LO  = RSP_STAT_LO + STAT_W;
   localparam int RSP_CNT_LO   = RSP_READ_LO + READ_W;
   localparam int RSP_BITS     = RSP_CNT_LO + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // commands
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BACK   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   // broadcast to every cell
   typedef struct packed {
      logic write_en;   // load the request value at the write index
      logic shift_en;   // cells above the shift base take their lower neighbor
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/indexed_list_buffer_core.sv
// ---------------------------------------------------------------------------
// indexed_list_buffer_core: ordered list store built from a row of cells
// Push, insert with shift up, pop, indexed and end reads, and clear.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata: command, position, value
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata: status, read_value, count
//
//  one request per cycle: decode, cell update and response register write
//  share the accept cycle; the response appears the cycle after acceptance.
//  the read path is an or-reduce over the cells' addressed outputs.
//  a new request is taken while the response register is empty or drains.
//  reset clears the element count and the response valid; cells keep data.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_buffer_core
   import ilb_pkg::*;
#(
   parameter int DEPTH         = DEF_DEPTH,
   parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // command [2:0], position [9:3], value [41:10], zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status [1:0], read_value [33:2], count [40:34], zero fill
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic [CMD_W-1:0]         cmd;
   logic [IDX_W-1:0]         pos;
   logic [ELEMENT_WIDTH-1:0] value;
   logic                     accept;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  count_x;
   logic [IDX_W-1:0]  last_x;
   logic              empty;
   logic              full;

   cell_ctl_type      ctl;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic              rd_ok;
   logic [STAT_W-1:0] status;

   logic [ELEMENT_WIDTH-1:0] cell_data [DEPTH];
   logic [ELEMENT_WIDTH-1:0] cell_rd   [DEPTH];
   logic [ELEMENT_WIDTH-1:0] rd_word;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STAT_W-1:0]        rsp_stat_ff;
   logic [READ_W-1:0]        rsp_read_ff;
   logic [COUNT_W-1:0]       rsp_cnt_ff;

   assign cmd   = req_tdata[REQ_CMD_LO +: CMD_W];
   assign pos   = IDX_W'(req_tdata[REQ_POS_LO +: POS_W]);
   assign value = ELEMENT_WIDTH'(req_tdata[REQ_VAL_LO +: VALUE_W]);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign count_x = IDX_W'(count_ff);
   assign last_x  = IDX_W'(count_ff - CNT_W'(1));
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_COUNT);

   always_comb begin
      ctl.write_en = 1'b0;
      ctl.shift_en = 1'b0;
      wr_idx       = count_x;
      rd_idx       = last_x;
      rd_ok        = 1'b0;
      status       = ST_OK;
      count_in     = count_ff;
      unique case (cmd)
         CMD_PUSH: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctl.write_en = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            wr_idx = pos;
            priority if (pos > count_x) begin
               status = ST_INDEX;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctl.write_en = accept;
               ctl.shift_en = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_ok    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_READ: begin
            rd_idx = pos;
            priority if (empty) begin
               status = ST_EMPTY;
            end else if (pos >= count_x) begin
               status = ST_INDEX;
            end else begin
               rd_ok = 1'b1;
            end
         end
         CMD_FRONT: begin
            rd_idx = '0;
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_ok = 1'b1;
            end
         end
         CMD_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_ok = 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] lower;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_rest
         assign lower = cell_data[i-1];
      end

      ilb_cell #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .IDX_W         (IDX_W),
         .INDEX         (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .wr_idx     (wr_idx),
         .shift_base (pos),
         .rd_idx     (rd_idx),
         .load_data  (value),
         .lower_data (lower),
         .data       (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // only the addressed cell drives nonzero
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_stat_ff <= status;
         rsp_read_ff <= rd_ok ? READ_W'(rd_word) : '0;
         rsp_cnt_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_cnt_ff, rsp_read_ff, rsp_stat_ff});

endmodule

`default_nettype wire

### src/ilb_cell.sv
// ---------------------------------------------------------------------------
// ilb_cell: one element slot of the list
// Loads the request value, takes its lower neighbor on insert, and drives
// its element onto the read bus when addressed.
// ---------------------------------------------------------------------------
`default_nettype none

module ilb_cell
   import ilb_pkg::*;
#(
   parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH,
   parameter int IDX_W         = 7,
   parameter int INDEX         = 0
) (
   input  wire logic                     clock,
   input  wire cell_ctl_type             ctl,
   input  wire logic [IDX_W-1:0]         wr_idx,
   input  wire logic [IDX_W-1:0]         shift_base,
   input  wire logic [IDX_W-1:0]         rd_idx,
   input  wire logic [ELEMENT_WIDTH-1:0] load_data,
   input  wire logic [ELEMENT_WIDTH-1:0] lower_data,
   output logic      [ELEMENT_WIDTH-1:0] data,
   output logic      [ELEMENT_WIDTH-1:0] rd_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ELEMENT_WIDTH-1:0] elem_ff;
   logic [ELEMENT_WIDTH-1:0] elem_in;
   logic                     load;
   logic                     shift;

   assign load  = ctl.write_en && (wr_idx == MY_IDX);
   assign shift = ctl.shift_en && (MY_IDX > shift_base);

   always_comb begin
      priority if (load) begin
         elem_in = load_data;
      end else if (shift) begin
         elem_in = lower_data;
      end else begin
         elem_in = elem_ff;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign data    = elem_ff;
   assign rd_data = (rd_idx == MY_IDX) ? elem_ff : '0;

endmodule

`default_nettype wire

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for indexed_list_buffer_core
// Drives list commands on the request stream, keeps its own copy of the
// list to predict status, read value and count, and checks every response
// in order. Runs a directed opening, then fill, drain and mixed sequences
// under three idling patterns and one long response stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ilb_pkg::*;

   localparam int               LIST_DEPTH   = DEF_DEPTH;
   localparam int               LIST_IDX_W   = $clog2(LIST_DEPTH);
   localparam int               PHASE_ITEMS  = 270;
   localparam int               STALL_CYCLES = 250;
   localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      logic [CMD_W-1:0]   cmd;
   } list_req_t;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [READ_W-1:0]  read_value;
      logic [STAT_W-1:0]  status;
   } list_rsp_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   indexed_list_buffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // predicted list contents
   logic [DEF_ELEMENT_WIDTH-1:0] list_cells [LIST_DEPTH];
   int                           list_len = 0;

   list_req_t pending_reqs [$];
   list_rsp_t expected_rsps [$];
   list_req_t cur_req;
   bit        req_taken    = 1'b0;
   int        idle_mode    = 0;
   bit        hold_request = 1'b0;
   int        hold_left    = 0;
   int        gen_count    = 0;
   int        mismatches   = 0;
   int        accepted     = 0;
   int        responses    = 0;
   int        status_hits [4];

   function automatic list_rsp_t apply_list_request(input list_req_t r);
      list_rsp_t rsp;
      int        src;
      int        dst;
      rsp = '0;
      rsp.status = ST_OK;
      case (r.cmd)
         CMD_PUSH: begin
            if (list_len >= LIST_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               list_cells[list_len[LIST_IDX_W-1:0]] = r.value;
               list_len++;
            end
         end
         CMD_INSERT: begin
            // index test comes before the full test
            if (r.pos > list_len) begin
               rsp.status = ST_INDEX;
            end else if (list_len >= LIST_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               for (int i = list_len; i > r.pos; i--) begin
                  dst = i;
                  src = i - 1;
                  list_cells[dst[LIST_IDX_W-1:0]] = list_cells[src[LIST_IDX_W-1:0]];
               end
               list_cells[r.pos[LIST_IDX_W-1:0]] = r.value;
               list_len++;
            end
         end
         CMD_POP: begin
            if (list_len == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               list_len--;
               rsp.read_value = list_cells[list_len[LIST_IDX_W-1:0]];
            end
         end
         CMD_READ: begin
            if (list_len == 0)
               rsp.status = ST_EMPTY;
            else if (r.pos >= list_len)
               rsp.status = ST_INDEX;
            else
               rsp.read_value = list_cells[r.pos[LIST_IDX_W-1:0]];
         end
         CMD_FRONT: begin
            if (list_len == 0)
               rsp.status = ST_EMPTY;
            else
               rsp.read_value = list_cells[0];
         end
         CMD_BACK: begin
            if (list_len == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               src = list_len - 1;
               rsp.read_value = list_cells[src[LIST_IDX_W-1:0]];
            end
         end
         CMD_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      rsp.count = list_len[COUNT_W-1:0];
      return rsp;
   endfunction

   function automatic void check_field(input string name, input logic [READ_W-1:0] want,
                                       input logic [READ_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------- stimulus generation ----------------

   task automatic add_req(input logic [CMD_W-1:0] cmd, input int pos,
                          input logic [VALUE_W-1:0] value);
      list_req_t r;
      r.cmd   = cmd;
      r.pos   = pos[POS_W-1:0];
      r.value = value;
      pending_reqs.push_back(r);
      // track only the length so positions can be aimed at valid indexes
      case (cmd)
         CMD_PUSH:   if (gen_count < LIST_DEPTH) gen_count++;
         CMD_INSERT: if (pos <= gen_count && gen_count < LIST_DEPTH) gen_count++;
         CMD_POP:    if (gen_count > 0) gen_count--;
         CMD_CLEAR:  gen_count = 0;
         default: begin
         end
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic int valid_read_pos();
      return (gen_count > 0) ? $urandom_range(0, gen_count - 1) : $urandom_range(0, 127);
   endfunction

   function automatic int insert_pos();
      return ($urandom_range(0, 4) != 0) ? $urandom_range(0, gen_count) :
                                           $urandom_range(0, 127);
   endfunction

   task automatic add_mixed_req();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)      add_req(CMD_PUSH, $urandom_range(0, 127), rand_value());
      else if (r < 50) add_req(CMD_INSERT, insert_pos(), rand_value());
      else if (r < 65) add_req(CMD_POP, $urandom_range(0, 127), rand_value());
      else if (r < 80) add_req(CMD_READ, ($urandom_range(0, 4) != 0) ? valid_read_pos() :
                               $urandom_range(0, 127), rand_value());
      else if (r < 87) add_req(CMD_FRONT, $urandom_range(0, 127), rand_value());
      else if (r < 94) add_req(CMD_BACK, $urandom_range(0, 127), rand_value());
      else if (r < 97) add_req(CMD_CLEAR, $urandom_range(0, 127), rand_value());
      else             add_req(CMD_UNUSED, $urandom_range(0, 127), rand_value());
   endtask

   // fill to capacity, then poke at the full list
   task automatic add_fill_run();
      while (gen_count < LIST_DEPTH) begin
         if ($urandom_range(0, 1) == 0)
            add_req(CMD_PUSH, $urandom_range(0, 127), rand_value());
         else
            add_req(CMD_INSERT, $urandom_range(0, gen_count), rand_value());
         if ($urandom_range(0, 7) == 0)
            add_req(CMD_READ, valid_read_pos(), rand_value());
      end
      add_req(CMD_PUSH, $urandom_range(0, 127), rand_value());
      add_req(CMD_INSERT, $urandom_range(0, LIST_DEPTH), rand_value());
      add_req(CMD_INSERT, $urandom_range(LIST_DEPTH + 1, 127), rand_value());
      add_req(CMD_READ, valid_read_pos(), rand_value());
      add_req(CMD_BACK, $urandom_range(0, 127), rand_value());
   endtask

   // empty the list, then poke at the empty list
   task automatic add_drain_run();
      while (gen_count > 0) begin
         if ($urandom_range(0, 5) == 0)
            add_req(CMD_READ, valid_read_pos(), rand_value());
         else
            add_req(CMD_POP, $urandom_range(0, 127), rand_value());
      end
      add_req(CMD_POP, $urandom_range(0, 127), rand_value());
      add_req(CMD_FRONT, $urandom_range(0, 127), rand_value());
      add_req(CMD_READ, $urandom_range(0, 127), rand_value());
   endtask

   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // ---------------- driver ----------------

   always @(negedge clock) begin
      bit offer;
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 19 : (idle_mode == 1) ? 83 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         offer = pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct;
         if (offer) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= {{(REQ_TDATA_W-REQ_BITS){1'b0}}, cur_req};
         end
         req_tvalid <= offer;
      end
   end

   // ---------------- response receiver ----------------

   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 83 : (idle_mode == 1) ? 19 : 0;
      if (hold_request) begin
         hold_left    = STALL_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= idle_pct;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      list_rsp_t got;
      list_rsp_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tdata[RSP_STAT_LO +: STAT_W];
            got.read_value = rsp_tdata[RSP_READ_LO +: READ_W];
            got.count      = rsp_tdata[RSP_CNT_LO +: COUNT_W];
            responses++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0h", $time, got);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               status_hits[want.status]++;
               check_field("status", READ_W'(want.status), READ_W'(got.status));
               check_field("read_value", want.read_value, got.read_value);
               check_field("count", READ_W'(want.count), READ_W'(got.count));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_list_request(cur_req));
            req_taken = 1'b1;
            accepted++;
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int phase_items;
      int start_size;
      foreach (status_hits[i]) status_hits[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list corner cases, then a few elements and their edges
      add_req(CMD_FRONT, 0, '0);
      add_req(CMD_BACK, 0, '0);
      add_req(CMD_POP, 0, '0);
      add_req(CMD_READ, 0, '0);
      add_req(CMD_INSERT, 1, 32'h1111_1111);
      add_req(CMD_UNUSED, 127, '1);
      add_req(CMD_CLEAR, 0, '0);
      add_req(CMD_INSERT, 0, 32'hFFFF_FFFF);
      add_req(CMD_PUSH, 0, 32'h0000_0000);
      add_req(CMD_INSERT, 2, 32'hA5A5_A5A5);
      add_req(CMD_INSERT, 1, 32'h1234_5678);
      add_req(CMD_READ, 0, '0);
      add_req(CMD_READ, 3, '0);
      add_req(CMD_READ, 4, '0);
      add_req(CMD_READ, 127, '1);
      add_req(CMD_INSERT, 127, 32'h5A5A_5A5A);
      add_req(CMD_FRONT, 0, '0);
      add_req(CMD_BACK, 0, '0);
      add_req(CMD_UNUSED, 0, '0);
      add_req(CMD_POP, 0, '0);
      add_req(CMD_PUSH, 64, 32'h8000_0001);
      add_req(CMD_CLEAR, 0, '0);
      add_req(CMD_CLEAR, 0, '0);
      wait_for_drain();

      for (int ph = 0; ph < 3; ph++) begin
         idle_mode   = ph;
         phase_items = 0;
         if (ph == 0) add_fill_run();
         while (phase_items < PHASE_ITEMS) begin
            start_size = pending_reqs.size();
            case ($urandom_range(0, 7))
               0, 1: add_fill_run();
               2:    add_drain_run();
               default: repeat (24) add_mixed_req();
            endcase
            phase_items += pending_reqs.size() - start_size;
         end
         // stall the response side while requests keep coming
         if (ph == 2) hold_request = 1'b1;
         // sender stays quiet until every response is back
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      $display("run: %0d requests accepted, %0d responses checked", accepted, responses);
      $display("statuses seen: ok %0d, index %0d, empty %0d, full %0d",
               status_hits[ST_OK], status_hits[ST_INDEX], status_hits[ST_EMPTY],
               status_hits[ST_FULL]);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("timeout: %0d responses still pending", expected_rsps.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### sim.f
src/ilb_pkg.sv
src/ilb_cell.sv
src/indexed_list_buffer_core.sv
sim/tb_top.sv
